>>> src/ssd_pkg.sv
`default_nettype none
package ssd_pkg;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int QBITS = 17;
   localparam int DIST_WIDTH = QBITS;
   localparam int LANES = 4;
   localparam int PREP_STAGES = 6;
   localparam int CROSS_STAGES = 4;

   // coordinates are read at 8 to 29 bits
   function automatic int eff_width(input int w);
      return (w < 8) ? 8 : ((w > 29) ? 29 : w);
   endfunction
endpackage
`default_nettype wire

>>> src/ssd_ifs.sv
`default_nettype none
interface ssd_req_if #(parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;
   logic signed [COORD_WIDTH-1:0] c_x;
   logic signed [COORD_WIDTH-1:0] c_y;
   logic signed [COORD_WIDTH-1:0] d_x;
   logic signed [COORD_WIDTH-1:0] d_y;
   modport source(output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
   modport sink(input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface ssd_rsp_if;
   logic valid;
   logic ready;
   logic [ssd_pkg::DIST_WIDTH-1:0] distance;
   logic crossing;
   modport source(output valid, distance, crossing, input ready);
   modport sink(input valid, distance, crossing, output ready);
endinterface
`default_nettype wire

>>> src/segment_to_segment_distance_top.sv
// Throughput: one word per cycle; the whole pipe holds while rsp is stalled.
// Latency is set by the 6-stage geometry front end, the 17-stage
// bit-per-stage root/quotient search and one output stage.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
`default_nettype none
module segment_to_segment_distance_top #(
   parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ssd_req_if.sink       req_bus,
   ssd_rsp_if.source     rsp_bus
);
   import ssd_pkg::*;

   localparam int EW = eff_width(COORD_WIDTH);
   localparam int CW = 4 * EW + 2;
   localparam int LW = 2 * EW + 1;
   localparam int LAT = PREP_STAGES + QBITS + 1;
   localparam int XDLY = PREP_STAGES + QBITS - CROSS_STAGES;

   logic                 en;
   logic [LAT-1:0]       vld_ff;
   logic [XDLY-1:0]      xd_ff;
   logic signed [EW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
   logic signed [EW-1:0] px [LANES];
   logic signed [EW-1:0] py [LANES];
   logic signed [EW-1:0] sx [LANES];
   logic signed [EW-1:0] sy [LANES];
   logic signed [EW-1:0] ex [LANES];
   logic signed [EW-1:0] ey [LANES];
   logic [CW-1:0]        lc [LANES];
   logic [LW-1:0]        ll [LANES];
   logic [QBITS-1:0]     lq [LANES];
   logic [QBITS-1:0]     best;
   logic                 cross_w;
   logic [DIST_WIDTH-1:0] dist_ff;
   logic                 crossing_ff;

   assign en = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = en;

   assign ax = req_bus.a_x[EW-1:0];
   assign ay = req_bus.a_y[EW-1:0];
   assign bx = req_bus.b_x[EW-1:0];
   assign by = req_bus.b_y[EW-1:0];
   assign cx = req_bus.c_x[EW-1:0];
   assign cy = req_bus.c_y[EW-1:0];
   assign dx = req_bus.d_x[EW-1:0];
   assign dy = req_bus.d_y[EW-1:0];

   // lanes: C to AB, D to AB, A to CD, B to CD
   always_comb begin
      px[0] = cx; py[0] = cy; sx[0] = ax; sy[0] = ay; ex[0] = bx; ey[0] = by;
      px[1] = dx; py[1] = dy; sx[1] = ax; sy[1] = ay; ex[1] = bx; ey[1] = by;
      px[2] = ax; py[2] = ay; sx[2] = cx; sy[2] = cy; ex[2] = dx; ey[2] = dy;
      px[3] = bx; py[3] = by; sx[3] = cx; sy[3] = cy; ex[3] = dx; ey[3] = dy;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      ssd_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
         .clock(clock), .en(en),
         .p_x(px[i]), .p_y(py[i]), .s_x(sx[i]), .s_y(sy[i]), .e_x(ex[i]), .e_y(ey[i]),
         .c_o(lc[i]), .l_o(ll[i])
      );
      ssd_solve #(.COORD_WIDTH(COORD_WIDTH)) u_solve (
         .clock(clock), .en(en), .c_i(lc[i]), .l_i(ll[i]), .q_o(lq[i])
      );
   end

   ssd_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock(clock), .en(en),
      .a_x(ax), .a_y(ay), .b_x(bx), .b_y(by),
      .c_x(cx), .c_y(cy), .d_x(dx), .d_y(dy),
      .cross_o(cross_w)
   );

   always_comb begin
      best = lq[0];
      for (int i = 1; i < LANES; i++) begin
         if (lq[i] < best) begin
            best = lq[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff       <= {xd_ff[XDLY-2:0], cross_w};
         crossing_ff <= xd_ff[XDLY-1];
         dist_ff     <= xd_ff[XDLY-1] ? '0 : DIST_WIDTH'(best);
      end
   end

   assign rsp_bus.valid    = vld_ff[LAT-1];
   assign rsp_bus.distance = dist_ff;
   assign rsp_bus.crossing = crossing_ff;
endmodule
`default_nettype wire

>>> src/ssd_prep.sv
`default_nettype none
module ssd_prep #(
   parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF,
   localparam int EW = ssd_pkg::eff_width(COORD_WIDTH),
   localparam int CW = 4 * EW + 2,
   localparam int LW = 2 * EW + 1
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [EW-1:0] p_x,
   input  logic signed [EW-1:0] p_y,
   input  logic signed [EW-1:0] s_x,
   input  logic signed [EW-1:0] s_y,
   input  logic signed [EW-1:0] e_x,
   input  logic signed [EW-1:0] e_y,
   output logic [CW-1:0]        c_o,
   output logic [LW-1:0]        l_o
);
   localparam int DW = EW + 1;
   localparam int PW = 2 * EW + 2;
   localparam int SW = 2 * EW + 3;
   localparam int MW = 2 * EW + 1;
   localparam int HL = (MW + 1) / 2;
   localparam int HH = MW - HL;

   logic signed [DW-1:0] bx_ff, by_ff, qx_ff, qy_ff, rx_ff, ry_ff;
   logic signed [PW-1:0] bbx_ff, bby_ff, qqx_ff, qqy_ff, rrx_ff, rry_ff;
   logic signed [PW-1:0] tx_ff, ty_ff, c1_ff, c2_ff;
   logic signed [SW-1:0] len2_ff, t_ff, cr_ff, ptq_ff, ptr_ff;
   logic                 perp_in, perp4_ff, perp5_ff;
   logic [CW-1:0]        cpt_in, cpt4_ff, cpt5_ff, c_ff;
   logic [LW-1:0]        l_in, l4_ff, l5_ff, l6_ff;
   logic [SW-1:0]        crabs;
   logic [HL-1:0]        mlo_ff;
   logic [HH-1:0]        mhi_ff;
   logic [2*HL-1:0]      ll_ff;
   logic [HL+HH-1:0]     lh_ff;
   logic [2*HH-1:0]      hh_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         bx_ff <= DW'(e_x) - DW'(s_x);
         by_ff <= DW'(e_y) - DW'(s_y);
         qx_ff <= DW'(p_x) - DW'(s_x);
         qy_ff <= DW'(p_y) - DW'(s_y);
         rx_ff <= DW'(p_x) - DW'(e_x);
         ry_ff <= DW'(p_y) - DW'(e_y);

         bbx_ff <= bx_ff * bx_ff;
         bby_ff <= by_ff * by_ff;
         qqx_ff <= qx_ff * qx_ff;
         qqy_ff <= qy_ff * qy_ff;
         rrx_ff <= rx_ff * rx_ff;
         rry_ff <= ry_ff * ry_ff;
         tx_ff  <= qx_ff * bx_ff;
         ty_ff  <= qy_ff * by_ff;
         c1_ff  <= bx_ff * qy_ff;
         c2_ff  <= by_ff * qx_ff;

         len2_ff <= SW'(bbx_ff) + SW'(bby_ff);
         t_ff    <= SW'(tx_ff) + SW'(ty_ff);
         cr_ff   <= SW'(c1_ff) - SW'(c2_ff);
         ptq_ff  <= SW'(qqx_ff) + SW'(qqy_ff);
         ptr_ff  <= SW'(rrx_ff) + SW'(rry_ff);
      end
   end

   always_comb begin
      crabs = cr_ff[SW-1] ? SW'(-cr_ff) : SW'(cr_ff);
      perp_in = 1'b0;
      cpt_in = CW'(ptq_ff);
      if (len2_ff == '0 || t_ff < 0) begin
         cpt_in = CW'(ptq_ff);
      end else if (t_ff > len2_ff) begin
         cpt_in = CW'(ptr_ff);
      end else begin
         perp_in = 1'b1;
      end
      l_in = perp_in ? len2_ff[LW-1:0] : LW'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         perp4_ff <= perp_in;
         cpt4_ff  <= cpt_in;
         l4_ff    <= l_in;
         mlo_ff   <= crabs[HL-1:0];
         mhi_ff   <= crabs[MW-1:HL];

         ll_ff    <= mlo_ff * mlo_ff;
         lh_ff    <= mlo_ff * mhi_ff;
         hh_ff    <= mhi_ff * mhi_ff;
         perp5_ff <= perp4_ff;
         cpt5_ff  <= cpt4_ff;
         l5_ff    <= l4_ff;

         c_ff  <= perp5_ff ? ((CW'(hh_ff) << (2 * HL)) + (CW'(lh_ff) << (HL + 1))
                              + CW'(ll_ff)) : cpt5_ff;
         l6_ff <= l5_ff;
      end
   end

   assign c_o = c_ff;
   assign l_o = l6_ff;
endmodule
`default_nettype wire

>>> src/ssd_solve.sv
`default_nettype none
module ssd_solve #(
   parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF,
   localparam int EW = ssd_pkg::eff_width(COORD_WIDTH),
   localparam int CW = 4 * EW + 2,
   localparam int LW = 2 * EW + 1
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [CW-1:0]              c_i,
   input  logic [LW-1:0]              l_i,
   output logic [ssd_pkg::QBITS-1:0]  q_o
);
   import ssd_pkg::*;

   // largest q with q*q*l <= c, one bit per stage
   localparam int XA = LW + 2 * QBITS + 1;
   localparam int XW = (CW > XA) ? CW : XA;
   localparam int SXW = LW + QBITS;

   logic [XW-1:0]    r_ff [QBITS-1];
   logic [SXW-1:0]   s_ff [QBITS-1];
   logic [LW-1:0]    l_ff [QBITS-1];
   logic [QBITS-1:0] q_ff [QBITS];

   logic [XW-1:0]    r_cur [QBITS];
   logic [SXW-1:0]   s_cur [QBITS];
   logic [LW-1:0]    l_cur [QBITS];
   logic [QBITS-1:0] q_cur [QBITS];
   logic [XW-1:0]    tst   [QBITS];
   logic [QBITS-1:0] take;

   always_comb begin
      r_cur[0] = XW'(c_i);
      s_cur[0] = '0;
      l_cur[0] = l_i;
      q_cur[0] = '0;
      for (int k = 1; k < QBITS; k++) begin
         r_cur[k] = r_ff[k-1];
         s_cur[k] = s_ff[k-1];
         l_cur[k] = l_ff[k-1];
         q_cur[k] = q_ff[k-1];
      end
      for (int k = 0; k < QBITS; k++) begin
         tst[k] = (XW'(s_cur[k]) << (QBITS - k)) + (XW'(l_cur[k]) << (2 * (QBITS - 1 - k)));
         take[k] = tst[k] <= r_cur[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QBITS; k++) begin
            q_ff[k] <= take[k] ? (q_cur[k] | (QBITS'(1) << (QBITS - 1 - k))) : q_cur[k];
         end
         for (int k = 0; k < QBITS - 1; k++) begin
            r_ff[k] <= take[k] ? r_cur[k] - tst[k] : r_cur[k];
            s_ff[k] <= take[k] ? s_cur[k] + (SXW'(l_cur[k]) << (QBITS - 1 - k)) : s_cur[k];
            l_ff[k] <= l_cur[k];
         end
      end
   end

   assign q_o = q_ff[QBITS-1];
endmodule
`default_nettype wire

>>> src/ssd_cross.sv
`default_nettype none
module ssd_cross #(
   parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF,
   localparam int EW = ssd_pkg::eff_width(COORD_WIDTH)
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [EW-1:0] a_x,
   input  logic signed [EW-1:0] a_y,
   input  logic signed [EW-1:0] b_x,
   input  logic signed [EW-1:0] b_y,
   input  logic signed [EW-1:0] c_x,
   input  logic signed [EW-1:0] c_y,
   input  logic signed [EW-1:0] d_x,
   input  logic signed [EW-1:0] d_y,
   output logic                 cross_o
);
   localparam int DW = EW + 1;
   localparam int PW = 2 * EW + 2;
   localparam int SW = 2 * EW + 3;
   localparam int SW1 = SW + 1;

   logic signed [DW-1:0]  ux_ff, uy_ff, pcx_ff, pcy_ff, pdx_ff, pdy_ff, ex_ff, ey_ff;
   logic signed [PW-1:0]  p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [SW-1:0]  crc_ff, crd_ff, num_ff;
   logic signed [SW1-1:0] den;
   logic                  hit, cross_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff  <= DW'(b_x) - DW'(a_x);
         uy_ff  <= DW'(b_y) - DW'(a_y);
         pcx_ff <= DW'(c_x) - DW'(a_x);
         pcy_ff <= DW'(c_y) - DW'(a_y);
         pdx_ff <= DW'(d_x) - DW'(a_x);
         pdy_ff <= DW'(d_y) - DW'(a_y);
         ex_ff  <= DW'(d_x) - DW'(c_x);
         ey_ff  <= DW'(d_y) - DW'(c_y);

         p1_ff <= ux_ff * pcy_ff;
         p2_ff <= uy_ff * pcx_ff;
         p3_ff <= ux_ff * pdy_ff;
         p4_ff <= uy_ff * pdx_ff;
         p5_ff <= pcx_ff * ey_ff;
         p6_ff <= pcy_ff * ex_ff;

         crc_ff <= SW'(p1_ff) - SW'(p2_ff);
         crd_ff <= SW'(p3_ff) - SW'(p4_ff);
         num_ff <= SW'(p5_ff) - SW'(p6_ff);

         cross_ff <= hit;
      end
   end

   // on-line endpoints count as non-negative side
   always_comb begin
      den = SW1'(crd_ff) - SW1'(crc_ff);
      if (den >= 0) begin
         hit = (num_ff >= 0) && (SW1'(num_ff) <= den);
      end else begin
         hit = (num_ff <= 0) && (SW1'(num_ff) >= den);
      end
      hit = hit && (crc_ff[SW-1] != crd_ff[SW-1]);
   end

   assign cross_o = cross_ff;
endmodule
`default_nettype wire

>>> src/ssd_checker.sv
`default_nettype none
module ssd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ssd_pkg::DIST_WIDTH-1:0]  rsp_distance,
   input logic                            rsp_crossing
);
   a_cross_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crossing |-> rsp_distance == '0)
      else $error("crossing word with nonzero distance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance) && $stable(rsp_crossing))
      else $error("stalled rsp word changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready while output is empty");

   a_unused_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without output back-pressure");
endmodule

bind segment_to_segment_distance_top ssd_checker u_ssd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_distance(rsp_bus.distance),
   .rsp_crossing(rsp_bus.crossing)
);
`default_nettype wire
